// ===== src/ecg_frame_delta_decoder_core_assert.svh =====
`ifndef ECG_FRAME_DELTA_DECODER_CORE_ASSERT_SVH
`define ECG_FRAME_DELTA_DECODER_CORE_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define EFDD_ASSERT(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a trigger is followed by a consequence in the following cycle.
`define EFDD_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/efdd_pkg.sv =====
package efdd_pkg;

  localparam int FRAME_BYTES        = 132;
  localparam int FIRST_DELTA_OFFSET = 24;
  localparam int DELTA_STRIDE       = 12;
  localparam int DELTA_COUNT        = 9;

  localparam logic [7:0] SYNC_BYTE = 8'h80;
  localparam int BASE_BIAS         = 2048;

  localparam int POS_W    = 8;
  localparam int IDX_W    = 4;
  localparam int SAMPLE_W = 13;
  localparam int GAP_MAX  = (FIRST_DELTA_OFFSET > DELTA_STRIDE) ?
                            FIRST_DELTA_OFFSET : DELTA_STRIDE;
  localparam int GAP_W    = $clog2(GAP_MAX + 1);

  typedef struct packed {
    logic             take_base_hi;
    logic             emit_base;
    logic             emit_delta;
    logic [IDX_W-1:0] index;
  } efdd_dec_t;

endpackage

// ===== src/ecg_frame_delta_decoder_core.sv =====
// A completed sample word goes from the input register into the result register.
// Throughput: one byte per cycle unless stalled; the input register feeds the result
// register directly. A byte waits there only while out_stall_i holds a result word.
// Reset is asynchronous and active low; it clears the frame tracking, returns the decoder
// to hunting for sync, and empties both registers.
`include "ecg_frame_delta_decoder_core_assert.svh"

module ecg_frame_delta_decoder_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [7:0]                           rx_byte_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [efdd_pkg::SAMPLE_W-1:0] sample_o,
  output logic [efdd_pkg::IDX_W-1:0]           sample_index_o,
  output logic                                 frame_last_o
);

  logic                                 in_valid_q, in_valid_d;
  logic [7:0]                           in_byte_q, in_byte_d;
  logic                                 out_valid_q, out_valid_d;
  logic signed [efdd_pkg::SAMPLE_W-1:0] out_sample_q, out_sample_d;
  logic [efdd_pkg::IDX_W-1:0]           out_index_q, out_index_d;
  logic                                 out_last_q, out_last_d;

  efdd_pkg::efdd_dec_t                  dec;
  logic signed [efdd_pkg::SAMPLE_W-1:0] sample_next;
  logic                                 produce;
  logic                                 out_free;
  logic                                 step;
  logic                                 in_load;

  efdd_frame_ctrl u_frame_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .dec_o  (dec)
  );

  efdd_sample_acc u_sample_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .dec_i    (dec),
    .sample_o (sample_next)
  );

  always_comb begin
    produce    = dec.emit_base || dec.emit_delta;
    out_free   = !out_valid_q || !out_stall_i;
    step       = in_valid_q && (!produce || out_free);
    in_stall_o = in_valid_q && !step;
    in_load    = in_valid_i && !in_stall_o;

    in_valid_d = in_load ? 1'b1 : (step ? 1'b0 : in_valid_q);
    in_byte_d  = in_load ? rx_byte_i : in_byte_q;

    out_valid_d  = out_valid_q && out_stall_i;
    out_sample_d = out_sample_q;
    out_index_d  = out_index_q;
    out_last_d   = out_last_q;
    if (step && produce) begin
      out_valid_d  = 1'b1;
      out_sample_d = sample_next;
      out_index_d  = dec.index;
      out_last_d   = (dec.index == efdd_pkg::IDX_W'(efdd_pkg::DELTA_COUNT));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q    <= in_byte_d;
    out_sample_q <= out_sample_d;
    out_index_q  <= out_index_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign sample_o       = out_sample_q;
  assign sample_index_o = out_index_q;
  assign frame_last_o   = out_last_q;

  `EFDD_ASSERT_NEXT(a_result_loaded, clk_i, rst_ni, step && produce, out_valid_q,
    "decoded sample was not registered")
  `EFDD_ASSERT(a_last_index, clk_i, rst_ni,
    !(out_valid_q && out_last_q) ||
    (out_index_q == efdd_pkg::IDX_W'(efdd_pkg::DELTA_COUNT)),
    "frame_last on a sample that is not the final one")
  `EFDD_ASSERT(a_stall_cause, clk_i, rst_ni,
    !in_stall_o || (in_valid_q && produce && out_valid_q),
    "input stalled without a pending result")

endmodule

// ===== src/efdd_frame_ctrl.sv =====
`include "ecg_frame_delta_decoder_core_assert.svh"

module efdd_frame_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  output efdd_pkg::efdd_dec_t  dec_o
);

  logic                            collecting_q, collecting_d;
  logic [efdd_pkg::POS_W-1:0]      pos_q, pos_d;
  logic [efdd_pkg::GAP_W-1:0]      gap_q, gap_d;
  logic [efdd_pkg::IDX_W-1:0]      slot_q, slot_d;

  always_comb begin
    dec_o.take_base_hi = collecting_q && (pos_q == efdd_pkg::POS_W'(0));
    dec_o.emit_base    = collecting_q && (pos_q == efdd_pkg::POS_W'(1));
    dec_o.emit_delta   = collecting_q && (gap_q == '0) &&
                         (slot_q < efdd_pkg::IDX_W'(efdd_pkg::DELTA_COUNT));
    dec_o.index        = dec_o.emit_delta ? slot_q + efdd_pkg::IDX_W'(1) : '0;
  end

  always_comb begin
    collecting_d = collecting_q;
    pos_d        = pos_q;
    gap_d        = gap_q;
    slot_d       = slot_q;
    if (step_i) begin
      if (!collecting_q) begin
        if (byte_i == efdd_pkg::SYNC_BYTE) begin
          collecting_d = 1'b1;
          pos_d        = '0;
          gap_d        = efdd_pkg::GAP_W'(efdd_pkg::FIRST_DELTA_OFFSET);
          slot_d       = '0;
        end
      end else begin
        if (gap_q == '0) begin
          gap_d = efdd_pkg::GAP_W'(efdd_pkg::DELTA_STRIDE - 1);
          if (slot_q < efdd_pkg::IDX_W'(efdd_pkg::DELTA_COUNT)) begin
            slot_d = slot_q + efdd_pkg::IDX_W'(1);
          end
        end else begin
          gap_d = gap_q - efdd_pkg::GAP_W'(1);
        end
        if (pos_q == efdd_pkg::POS_W'(efdd_pkg::FRAME_BYTES - 1)) begin
          collecting_d = 1'b0;
          pos_d        = '0;
        end else begin
          pos_d = pos_q + efdd_pkg::POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      pos_q        <= '0;
      gap_q        <= '0;
      slot_q       <= '0;
    end else begin
      collecting_q <= collecting_d;
      pos_q        <= pos_d;
      gap_q        <= gap_d;
      slot_q       <= slot_d;
    end
  end

  `EFDD_ASSERT(a_one_kind, clk_i, rst_ni, !(dec_o.emit_base && dec_o.emit_delta),
    "base and delta decoded on the same byte")
  `EFDD_ASSERT(a_slot_range, clk_i, rst_ni,
    slot_q <= efdd_pkg::IDX_W'(efdd_pkg::DELTA_COUNT), "delta slot out of range")
  `EFDD_ASSERT(a_hunt_pos, clk_i, rst_ni, collecting_q || (pos_q == '0),
    "byte position nonzero while hunting")
  `EFDD_ASSERT_NEXT(a_sync_start, clk_i, rst_ni,
    step_i && !collecting_q && (byte_i == efdd_pkg::SYNC_BYTE), collecting_q,
    "sync byte did not start a frame")

endmodule

// ===== src/efdd_sample_acc.sv =====
module efdd_sample_acc (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic [7:0]                          byte_i,
  input  efdd_pkg::efdd_dec_t                 dec_i,
  output logic signed [efdd_pkg::SAMPLE_W-1:0] sample_o
);

  logic [5:0]                           base_hi_q, base_hi_d;
  logic signed [efdd_pkg::SAMPLE_W-1:0] run_q, run_d;
  logic signed [efdd_pkg::SAMPLE_W-1:0] base_val;
  logic signed [efdd_pkg::SAMPLE_W-1:0] delta_val;
  logic signed [efdd_pkg::SAMPLE_W-1:0] mag;

  always_comb begin
    base_val  = $signed({1'b0, base_hi_q, byte_i[5:0]}) -
                efdd_pkg::SAMPLE_W'(efdd_pkg::BASE_BIAS);
    mag       = $signed({{(efdd_pkg::SAMPLE_W - 6){1'b0}}, byte_i[5:0]});
    delta_val = (byte_i[7:6] == 2'b01) ? run_q - mag : run_q + mag;
    sample_o  = dec_i.emit_base ? base_val : delta_val;
  end

  always_comb begin
    base_hi_d = base_hi_q;
    run_d     = run_q;
    if (step_i) begin
      if (dec_i.take_base_hi) begin
        base_hi_d = byte_i[5:0];
      end
      if (dec_i.emit_base || dec_i.emit_delta) begin
        run_d = sample_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_hi_q <= '0;
      run_q     <= '0;
    end else begin
      base_hi_q <= base_hi_d;
      run_q     <= run_d;
    end
  end

endmodule
